>>> rtl/lmbsd_pkg.sv
// shared types, constants and routing tables for the led matrix bit plane scan driver
// no dependencies
package lmbsd_pkg;

   localparam int SCAN_ROWS = 6;
   localparam int COLUMNS   = 5;
   localparam int PLANES    = 8;
   localparam int NUM_POS   = 15;

   localparam int ROW_W     = 3;
   localparam int COL_W     = 3;
   localparam int PLANE_W   = 3;
   localparam int CHAN_W    = 8;
   localparam int PIX_W     = 3 * CHAN_W;
   localparam int DEPTH     = SCAN_ROWS * COLUMNS;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int POS_W     = 4;
   localparam int SEL_W     = 6;
   localparam int ON_W      = 15;
   localparam int PERIOD_W  = 16;
   localparam int REQ_W     = 40;
   localparam int RSP_W     = 48;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 16;

   localparam logic [SEL_W-1:0]    SEL_MASK   = 6'h3F;
   localparam logic [POS_W-1:0]    CTRL_POS   = 4'(NUM_POS);
   localparam logic [PERIOD_W-1:0] PERIOD_MAX = 16'hFFFF;

   localparam logic [7:0]  BASE_ON_RESET  = 8'h02;
   localparam logic [11:0] BLANK_RESET    = 12'h050;
   localparam logic [15:0] MIN_CYC_RESET  = 16'h005F;
   localparam logic [15:0] MIN_LAST_RESET = 16'h0120;

   typedef enum logic {
      REQ_WRITE  = 1'b0,
      REQ_RENDER = 1'b1
   } req_kind_type;

   typedef enum logic {
      RSP_SHIFT = 1'b0,
      RSP_CTRL  = 1'b1
   } rsp_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_ON_TIME   = 2'd0,
      CSR_BLANKING_TIME  = 2'd1,
      CSR_MIN_CYCLE      = 2'd2,
      CSR_MIN_LAST_CYCLE = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      CHAN_RED   = 2'd0,
      CHAN_GREEN = 2'd1,
      CHAN_BLUE  = 2'd2
   } chan_type;

   typedef struct packed {
      logic [7:0]  base_on_time;
      logic [11:0] blanking_time;
      logic [15:0] slot_floor;
      logic [15:0] last_slot_floor;
   } csr_type;

   typedef struct packed {
      logic [SEL_W-1:0]    hold_select;
      logic [SEL_W-1:0]    new_select;
      logic [ON_W-1:0]     on_time;
      logic [PERIOD_W-1:0] period;
   } slot_ctrl_type;

   // column feeding each serial position
   function automatic logic [COL_W-1:0] pos_col(input logic [POS_W-1:0] pos);
      logic [COL_W-1:0] c;
      case (pos)
         4'd0:    c = 3'd3;
         4'd1:    c = 3'd4;
         4'd2:    c = 3'd4;
         4'd3:    c = 3'd4;
         4'd4:    c = 3'd2;
         4'd5:    c = 3'd3;
         4'd6:    c = 3'd1;
         4'd7:    c = 3'd0;
         4'd8:    c = 3'd0;
         4'd9:    c = 3'd2;
         4'd10:   c = 3'd2;
         4'd11:   c = 3'd1;
         4'd12:   c = 3'd1;
         4'd13:   c = 3'd0;
         4'd14:   c = 3'd3;
         default: c = 3'd0;
      endcase
      return c;
   endfunction

   // colour channel feeding each serial position
   function automatic chan_type pos_chan(input logic [POS_W-1:0] pos);
      chan_type ch;
      case (pos)
         4'd0, 4'd2, 4'd4, 4'd6, 4'd13:          ch = CHAN_BLUE;
         4'd1, 4'd8, 4'd10, 4'd12, 4'd14:        ch = CHAN_GREEN;
         default:                                ch = CHAN_RED;
      endcase
      return ch;
   endfunction

   function automatic logic [ADDR_W-1:0] pix_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
      return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
   endfunction

endpackage

>>> rtl/led_matrix_bitplane_scan_driver.sv
// top level of the led matrix bit plane scan driver: pixel store, scan sequencer, result register
// depends on lmbsd_pkg, lmbsd_ram and lmbsd_slot_ctrl
//
// a pixel write beat stores one rgb pixel and gives nothing back; a render beat names a scan
// row and bit plane and streams 16 result beats: 15 serial shift bits in routing order, then
// one control beat (tlast) with the active-low hold and strobed row selects, the output enable
// on time and the slot period. the pixel store is a 30 x 24 ram with a registered read, one
// entry read per shift bit. the issue stage walks the 15 reads and the control slot, then the
// read stage and the result register follow, and results leave one per cycle while the result
// side does not stall. the next beat is taken once the control slot has left the read stage.
// stalls freeze the read pipeline, the ram read data holds because no new read is issued.
// per-entry valid bits cleared by reset make unwritten pixels read as zero, so no clearing
// pass runs. renders with a row or plane out of range and writes with a row or column out of
// range are dropped. csr writes are registered and are only meant to happen while no render
// is in flight.
module led_matrix_bitplane_scan_driver (
   input  logic                              clock,
   input  logic                              reset,
   // slave side
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // row[2:0] col[5:3] red[13:6] green[21:14] blue[29:22] plane[32:30], zero pad above
   input  logic [lmbsd_pkg::REQ_W-1:0]       req_tdata,
   // req_type[0]
   input  logic                              req_tuser,
   // master side
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // position[3:0] data_bit[4] hold_select[10:5] new_select[16:11] on_time[31:17]
   // period[47:32]
   output logic [lmbsd_pkg::RSP_W-1:0]       rsp_tdata,
   // kind[0]
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   // configuration
   input  logic                              csr_we,
   input  logic [lmbsd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lmbsd_pkg::CSR_W-1:0]       csr_wdata
);
   import lmbsd_pkg::*;

   // request fields
   logic [ROW_W-1:0]   req_row;
   logic [COL_W-1:0]   req_col;
   logic [PIX_W-1:0]   req_pixel;
   logic [PLANE_W-1:0] req_plane;

   assign req_row   = req_tdata[2:0];
   assign req_col   = req_tdata[5:3];
   // stored as red, green, blue from the top down
   assign req_pixel = {req_tdata[13:6], req_tdata[21:14], req_tdata[29:22]};
   assign req_plane = req_tdata[32:30];

   // configuration registers
   csr_type csr_ff, csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_BASE_ON_TIME:   csr_in.base_on_time    = csr_wdata[7:0];
            CSR_BLANKING_TIME:  csr_in.blanking_time   = csr_wdata[11:0];
            CSR_MIN_CYCLE:      csr_in.slot_floor      = csr_wdata;
            CSR_MIN_LAST_CYCLE: csr_in.last_slot_floor = csr_wdata;
            default:            csr_in = csr_ff;
         endcase
      end
   end

   // sequencer state
   logic                  issue_active_ff, issue_active_in;
   logic [POS_W-1:0]      issue_pos_ff, issue_pos_in;
   logic                  b_valid_ff, b_valid_in;
   logic [POS_W-1:0]      b_pos_ff, b_pos_in;
   logic                  b_vld_ff, b_vld_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [PLANE_W-1:0]    plane_ff, plane_in;
   logic [DEPTH-1:0]      valid_ff, valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]      rsp_data_ff, rsp_data_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  req_accept;
   logic                  write_ok;
   logic                  render_ok;
   logic                  advance;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic [ADDR_W-1:0]     wr_addr;
   logic [PIX_W-1:0]      rd_data;
   logic [CHAN_W-1:0]     chan_byte;
   logic                  shift_bit;
   slot_ctrl_type         slot_ctrl;

   // the store is only touched by one beat at a time, so writes never meet a read
   assign req_tready = !issue_active_ff && !b_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign write_ok   = req_accept && (req_kind_type'(req_tuser) == REQ_WRITE)
                       && (int'(req_row) < SCAN_ROWS) && (int'(req_col) < COLUMNS);
   assign render_ok  = req_accept && (req_kind_type'(req_tuser) == REQ_RENDER)
                       && (int'(req_row) < SCAN_ROWS) && (int'(req_plane) < PLANES);

   // whole pipeline moves when the result register is free or being emptied
   assign advance = !rsp_valid_ff || rsp_tready;
   assign rd_en   = issue_active_ff && advance && (issue_pos_ff != CTRL_POS);
   assign rd_addr = pix_addr(row_ff, pos_col(issue_pos_ff));
   assign wr_addr = pix_addr(req_row, req_col);

   lmbsd_ram #(
      .DATA_W (PIX_W),
      .DEPTH  (DEPTH)
   ) u_pixel_ram (
      .clock   (clock),
      .wr_en   (write_ok),
      .wr_addr (wr_addr),
      .wr_data (req_pixel),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lmbsd_slot_ctrl u_slot_ctrl (
      .csr   (csr_ff),
      .row   (row_ff),
      .plane (plane_ff),
      .ctrl  (slot_ctrl)
   );

   // colour bit of the entry held by the read stage, zero for a never written pixel
   always_comb begin
      case (pos_chan(b_pos_ff))
         CHAN_RED:   chan_byte = rd_data[23:16];
         CHAN_GREEN: chan_byte = rd_data[15:8];
         CHAN_BLUE:  chan_byte = rd_data[7:0];
         default:    chan_byte = '0;
      endcase
      shift_bit = b_vld_ff && chan_byte[plane_ff];
   end

   // next state
   always_comb begin
      issue_active_in = issue_active_ff;
      issue_pos_in    = issue_pos_ff;
      b_valid_in      = b_valid_ff;
      b_pos_in        = b_pos_ff;
      b_vld_in        = b_vld_ff;
      row_in          = row_ff;
      plane_in        = plane_ff;
      valid_in        = valid_ff;

      if (write_ok) begin
         valid_in[wr_addr] = 1'b1;
      end

      if (render_ok) begin
         issue_active_in = 1'b1;
         issue_pos_in    = '0;
         row_in          = req_row;
         plane_in        = req_plane;
      end else if (issue_active_ff && advance) begin
         issue_pos_in = issue_pos_ff + POS_W'(1);
         if (issue_pos_ff == CTRL_POS) begin
            issue_active_in = 1'b0;
         end
      end

      if (advance) begin
         b_valid_in = issue_active_ff;
         b_pos_in   = issue_pos_ff;
      end
      if (rd_en) begin
         b_vld_in = valid_ff[rd_addr];
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = b_valid_ff;
         if (b_valid_ff) begin
            if (b_pos_ff == CTRL_POS) begin
               rsp_kind_in = RSP_CTRL;
               rsp_last_in = 1'b1;
               rsp_data_in = {slot_ctrl.period, slot_ctrl.on_time, slot_ctrl.new_select,
                              slot_ctrl.hold_select, 1'b0, POS_W'(0)};
            end else begin
               rsp_kind_in = RSP_SHIFT;
               rsp_last_in = 1'b0;
               rsp_data_in = {(RSP_W - POS_W - 1)'(0), shift_bit, b_pos_ff};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.base_on_time    <= BASE_ON_RESET;
         csr_ff.blanking_time   <= BLANK_RESET;
         csr_ff.slot_floor      <= MIN_CYC_RESET;
         csr_ff.last_slot_floor <= MIN_LAST_RESET;
         issue_active_ff        <= 1'b0;
         b_valid_ff             <= 1'b0;
         valid_ff               <= '0;
         rsp_valid_ff           <= 1'b0;
      end else begin
         csr_ff          <= csr_in;
         issue_active_ff <= issue_active_in;
         b_valid_ff      <= b_valid_in;
         valid_ff        <= valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      issue_pos_ff <= issue_pos_in;
      b_pos_ff     <= b_pos_in;
      b_vld_ff     <= b_vld_in;
      row_ff       <= row_in;
      plane_ff     <= plane_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   // a new beat only enters once the read pipeline has drained
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !issue_active_ff && !b_valid_ff)
      else $error("beat accepted while a render is in flight");

   // issue and read stages hold consecutive positions
   a_pos_order: assert property (@(posedge clock) disable iff (reset)
      issue_active_ff && b_valid_ff |-> issue_pos_ff == b_pos_ff + POS_W'(1))
      else $error("read pipeline positions out of order");

   // a stalled result freezes the read stage
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && rsp_tvalid && !rsp_tready |=> $stable(b_pos_ff) && b_valid_ff)
      else $error("read stage moved during a result stall");

   // only the control beat closes a run
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tlast == rsp_tuser)
      else $error("tlast and kind disagree");
`endif

endmodule

>>> rtl/lmbsd_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module lmbsd_ram #(
   parameter int DATA_W = 24,
   parameter int DEPTH  = 30,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/lmbsd_slot_ctrl.sv
// slot control values: row select patterns, on time and saturated period
// depends on lmbsd_pkg
module lmbsd_slot_ctrl (
   input  lmbsd_pkg::csr_type              csr,
   input  logic [lmbsd_pkg::ROW_W-1:0]     row,
   input  logic [lmbsd_pkg::PLANE_W-1:0]   plane,
   output lmbsd_pkg::slot_ctrl_type        ctrl
);
   import lmbsd_pkg::*;

   logic [ROW_W-1:0]    hold_row;
   logic [ON_W-1:0]     on_time;
   logic [PERIOD_W:0]   sum;
   logic [PERIOD_W-1:0] floor_time;
   logic [PERIOD_W:0]   period_full;
   logic                last_slot;

   always_comb begin
      // plane 0 keeps the previous row lit until the strobe
      if (plane == '0) begin
         hold_row = (row == '0) ? ROW_W'(SCAN_ROWS - 1) : row - ROW_W'(1);
      end else begin
         hold_row = row;
      end
      on_time     = ON_W'(csr.base_on_time) << plane;
      sum         = (PERIOD_W + 1)'(on_time) + (PERIOD_W + 1)'(csr.blanking_time);
      last_slot   = (row == ROW_W'(SCAN_ROWS - 1)) && (plane == PLANE_W'(PLANES - 2));
      floor_time  = last_slot ? csr.last_slot_floor : csr.slot_floor;
      period_full = (sum > {1'b0, floor_time}) ? sum : {1'b0, floor_time};

      ctrl.hold_select = SEL_MASK & ~(SEL_W'(1) << hold_row);
      ctrl.new_select  = SEL_MASK & ~(SEL_W'(1) << row);
      ctrl.on_time     = on_time;
      ctrl.period      = period_full[PERIOD_W] ? PERIOD_MAX : period_full[PERIOD_W-1:0];
   end

endmodule

>>> tb/tb.sv
// self-checking testbench for led_matrix_bitplane_scan_driver: pixel writes, row renders, csr
// settings; depends on lmbsd_pkg and the rtl of the block only
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lmbsd_pkg::*;

   localparam int MAX_GAP        = 8;
   localparam int SETTLE_CYCLES  = 24;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_ITEMS    = 50;

   // serial routing: column and colour channel behind each shift position
   localparam logic [2:0] ROUTE_COL [NUM_POS] = '{3, 4, 4, 4, 2, 3, 1, 0, 0, 2, 2, 1, 1, 0, 3};
   localparam chan_type ROUTE_CHAN [NUM_POS] = '{
      CHAN_BLUE, CHAN_GREEN, CHAN_BLUE, CHAN_RED, CHAN_BLUE, CHAN_RED, CHAN_BLUE, CHAN_RED,
      CHAN_GREEN, CHAN_RED, CHAN_GREEN, CHAN_RED, CHAN_GREEN, CHAN_BLUE, CHAN_GREEN};

   // one result beat, field by field
   typedef struct {
      rsp_kind_type         kind;
      logic [POS_W-1:0]     position;
      logic                 data_bit;
      logic [SEL_W-1:0]     hold_select;
      logic [SEL_W-1:0]     new_select;
      logic [ON_W-1:0]      on_time;
      logic [PERIOD_W-1:0]  period;
      logic                 last;
   } slot_beat_type;

   // keeps its own pixel store and csr copy, predicts the beats of each render
   class scan_slot_checker;
      logic [PIX_W-1:0]    pixels [DEPTH];
      logic [7:0]          base_on;
      logic [11:0]         blanking;
      logic [15:0]         min_cycle;
      logic [15:0]         min_last;
      slot_beat_type       beats_due [$];
      int                  errors;

      function new();
         foreach (pixels[i]) pixels[i] = '0;
         base_on   = BASE_ON_RESET;
         blanking  = BLANK_RESET;
         min_cycle = MIN_CYC_RESET;
         min_last  = MIN_LAST_RESET;
         errors    = 0;
      endfunction

      function void write_reg(csr_idx_type idx, logic [CSR_W-1:0] value);
         case (idx)
            CSR_BASE_ON_TIME:   base_on   = value[7:0];
            CSR_BLANKING_TIME:  blanking  = value[11:0];
            CSR_MIN_CYCLE:      min_cycle = value;
            CSR_MIN_LAST_CYCLE: min_last  = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return beats_due.size();
      endfunction

      // accepted request beat: update the store or queue the 16 beats of a slot
      function void take_request(req_kind_type kind, logic [2:0] row, logic [2:0] col,
                                 logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                                 logic [2:0] plane);
         slot_beat_type   b;
         logic [PIX_W-1:0] pix;
         logic [7:0]      level;
         logic [2:0]      hold_row;
         logic [ON_W-1:0] on;
         logic [16:0]     total;
         logic [15:0]     floor_time;
         if (kind == REQ_WRITE) begin
            // out of range pixels are dropped
            if (row < SCAN_ROWS && col < COLUMNS)
               pixels[int'(row) * COLUMNS + int'(col)] = {red, green, blue};
            return;
         end
         if (row >= SCAN_ROWS || plane >= PLANES)
            return;
         for (int p = 0; p < NUM_POS; p++) begin
            pix = pixels[int'(row) * COLUMNS + int'(ROUTE_COL[p])];
            case (ROUTE_CHAN[p])
               CHAN_RED:   level = pix[23:16];
               CHAN_GREEN: level = pix[15:8];
               default:    level = pix[7:0];
            endcase
            b.kind        = RSP_SHIFT;
            b.position    = POS_W'(p);
            b.data_bit    = level[plane];
            b.hold_select = '0;
            b.new_select  = '0;
            b.on_time     = '0;
            b.period      = '0;
            b.last        = 1'b0;
            beats_due.push_back(b);
         end
         // plane 0 holds the previous row, wrapping round from row 0
         if (plane == 0)
            hold_row = (row == 0) ? 3'(SCAN_ROWS - 1) : row - 3'd1;
         else
            hold_row = row;
         on = ON_W'(base_on);
         on = on << plane;
         total = 17'(on) + 17'(blanking);
         // the last row at the second-to-last plane has its own floor
         floor_time = (row == SCAN_ROWS - 1 && plane == PLANES - 2) ? min_last : min_cycle;
         if (total < 17'(floor_time))
            total = 17'(floor_time);
         b.kind        = RSP_CTRL;
         b.position    = '0;
         b.data_bit    = 1'b0;
         b.hold_select = SEL_MASK & ~(6'b1 << hold_row);
         b.new_select  = SEL_MASK & ~(6'b1 << row);
         b.on_time     = on;
         b.period      = (total > 17'(PERIOD_MAX)) ? PERIOD_MAX : total[15:0];
         b.last        = 1'b1;
         beats_due.push_back(b);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_beat(slot_beat_type got);
         slot_beat_type want;
         if (beats_due.size() == 0) begin
            $display("%0t: result beat with none expected, expected none actual kind %0d pos %0h",
                     $time, got.kind, got.position);
            errors++;
            return;
         end
         want = beats_due.pop_front();
         compare_field("kind", want.kind, got.kind);
         compare_field("position", want.position, got.position);
         compare_field("data_bit", want.data_bit, got.data_bit);
         compare_field("hold_select", want.hold_select, got.hold_select);
         compare_field("new_select", want.new_select, got.new_select);
         compare_field("on_time", want.on_time, got.on_time);
         compare_field("period", want.period, got.period);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // row[2:0] col[5:3] red[13:6] green[21:14] blue[29:22] plane[32:30], zero pad above
   logic [REQ_W-1:0]      req_tdata;
   // req_type[0]
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // position[3:0] data_bit[4] hold_select[10:5] new_select[16:11] on_time[31:17]
   // period[47:32]
   logic [RSP_W-1:0]      rsp_tdata;
   // kind[0]
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_W-1:0]      csr_wdata;

   scan_slot_checker      slots;
   bit                    no_idle;      // burst phase: neither side idles
   int                    idle_cycles;

   led_matrix_bitplane_scan_driver uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // one request beat: random idle gap, then hold valid until the block takes it.
   // valid stays high after the handshake so that back-to-back beats need no toggle
   task automatic send_beat(req_kind_type kind, logic [2:0] row, logic [2:0] col,
                            logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                            logic [2:0] plane);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'b0, plane, blue, green, red, col, row};
      do @(posedge clock); while (!req_tready);
      slots.take_request(kind, row, col, red, green, blue, plane);
   endtask

   // render with junk in the fields a render ignores
   task automatic send_render(logic [2:0] row, logic [2:0] plane);
      send_beat(REQ_RENDER, row, 3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom),
                8'($urandom), plane);
   endtask

   task automatic send_write(logic [2:0] row, logic [2:0] col,
                             logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      send_beat(REQ_WRITE, row, col, red, green, blue, 3'($urandom_range(0, 7)));
   endtask

   // stop sending, wait for every expected beat, then let the pipeline settle
   task automatic drain_slots();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (slots.pending() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      slots.write_reg(idx, value);
   endtask

   task automatic apply_settings(logic [CSR_W-1:0] base_on, logic [CSR_W-1:0] blanking,
                                 logic [CSR_W-1:0] min_cycle, logic [CSR_W-1:0] min_last);
      write_csr(CSR_BASE_ON_TIME, base_on);
      write_csr(CSR_BLANKING_TIME, blanking);
      write_csr(CSR_MIN_CYCLE, min_cycle);
      write_csr(CSR_MIN_LAST_CYCLE, min_last);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // mostly in-range writes and renders, a tenth noise that the block drops
   task automatic random_item();
      int pick;
      int noise;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         send_write(3'($urandom_range(0, SCAN_ROWS - 1)), 3'($urandom_range(0, COLUMNS - 1)),
                    8'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 90) begin
         send_render(3'($urandom_range(0, SCAN_ROWS - 1)), 3'($urandom_range(0, PLANES - 1)));
      end else begin
         noise = $urandom_range(0, 2);
         case (noise)
            0:       send_write(3'($urandom_range(SCAN_ROWS, 7)), 3'($urandom_range(0, 7)),
                                8'($urandom), 8'($urandom), 8'($urandom));
            1:       send_write(3'($urandom_range(0, 7)), 3'($urandom_range(COLUMNS, 7)),
                                8'($urandom), 8'($urandom), 8'($urandom));
            default: send_render(3'($urandom_range(SCAN_ROWS, 7)),
                                 3'($urandom_range(0, PLANES - 1)));
         endcase
      end
   endtask

   // one settings phase of random traffic, with a full drain half way through
   task automatic random_phase();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if (i == PHASE_ITEMS / 2)
            drain_slots();
         random_item();
      end
      drain_slots();
   endtask

   // result side: random stall before each beat, ready held until the beat moves
   initial begin
      int gap;
      rsp_tready = 1'b0;
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
         repeat (gap) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // result monitor: unpack each accepted beat and check it against the oldest prediction
   always @(posedge clock) begin : result_monitor
      slot_beat_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind        = rsp_kind_type'(rsp_tuser);
         got.position    = rsp_tdata[3:0];
         got.data_bit    = rsp_tdata[4];
         got.hold_select = rsp_tdata[10:5];
         got.new_select  = rsp_tdata[16:11];
         got.on_time     = rsp_tdata[31:17];
         got.period      = rsp_tdata[47:32];
         got.last        = rsp_tlast;
         slots.check_beat(got);
      end
   end

   // watchdog: any handshake or csr write counts as progress
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      slots       = new();
      no_idle     = 1'b0;
      idle_cycles = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tuser   = REQ_WRITE;
      req_tdata   = '0;
      csr_we      = 1'b0;
      csr_index   = CSR_BASE_ON_TIME;
      csr_wdata   = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part at the reset settings
      // render before any write: store reads as cleared
      send_render(3'd2, 3'd0);
      send_write(3'd0, 3'd0, 8'hFF, 8'hFF, 8'hFF);
      send_write(3'd0, 3'd4, 8'hAA, 8'h55, 8'hAA);
      send_write(3'd5, 3'd4, 8'hFF, 8'h00, 8'hFF);
      send_write(3'd5, 3'd0, 8'h01, 8'h80, 8'h7F);
      send_write(3'd3, 3'd2, 8'h55, 8'hAA, 8'h55);
      // out of range writes, must leave the store alone
      send_write(3'd6, 3'd0, 8'hFF, 8'hFF, 8'hFF);
      send_write(3'd7, 3'd7, 8'hFF, 8'hFF, 8'hFF);
      send_write(3'd2, 3'd5, 8'hFF, 8'hFF, 8'hFF);
      send_write(3'd0, 3'd7, 8'h00, 8'h00, 8'h00);
      // row 0 at plane 0: hold select wraps to the last row
      send_render(3'd0, 3'd0);
      send_render(3'd0, 3'd7);
      // last row at the second-to-last plane: own period floor
      send_render(3'd5, 3'd6);
      send_render(3'd5, 3'd0);
      send_render(3'd5, 3'd7);
      send_render(3'd4, 3'd6);
      send_render(3'd3, 3'd1);
      send_render(3'd3, 3'd4);
      // out of range render rows give no beats; the last two renders are in range
      send_render(3'd6, 3'd0);
      send_render(3'd7, 3'd7);
      send_render(3'd2, 3'd2);
      send_render(3'd0, 3'd3);
      drain_slots();

      // top of every range, zero floor on the last slot
      apply_settings(16'h00FF, 16'h0FFF, 16'hFFFF, 16'h0000);
      random_phase();
      // zero base time and all floors at zero
      apply_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      random_phase();
      apply_settings(16'h0001, 16'h000A, 16'h0014, 16'h012C);
      random_phase();
      // whole-word writes, upper bits of the narrow registers must be dropped
      apply_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      random_phase();
      // back to the reset values with both sides running flat out
      no_idle = 1'b1;
      apply_settings(16'(BASE_ON_RESET), 16'(BLANK_RESET), MIN_CYC_RESET, MIN_LAST_RESET);
      random_phase();
      no_idle = 1'b0;

      if (slots.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
